// ===== sv/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// shared types and constants of the sorted deadline timer queue
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 32;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [SLOT_W-1:0]     slot_t;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_ONESHOT = 2'd1;
    localparam logic [1:0] ACT_PERIODIC = 2'd2;
    localparam logic [1:0] ACT_CANCEL = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NOTQ    = 2'd2;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_REMOVE
    } cmd_t;

    typedef struct packed {
        cmd_t  cmd;
        slot_t slot;
        time_t dl;
    } bcast_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic  valid;
        slot_t slot;
        time_t dl;
        logic  ins_here;  // new entry goes at or before this cell
        logic  rm_here;   // removed entry is at or before this cell
    } cell_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_TICK,
        S_REQ,
        S_STATUS
    } state_t;

    // true when a is strictly after b over the wrapping range
    function automatic logic after(time_t a, time_t b);
        time_t d;
        d = a - b;
        return (d != '0) && !d[TIME_WIDTH-1];
    endfunction

endpackage

// ===== sv/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// sdtq_cell
// one queue position: holds a slot and its deadline, shifts with neighbors
// ----------------------------------------------------------------------------
module sdtq_cell
    import sdtq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  bcast_t bc,
    input  cell_t  prev,   // cell toward the head
    input  cell_t  nxt,    // cell toward the tail
    output cell_t  self
);
    logic  valid_reg;
    slot_t slot_reg;
    time_t dl_reg;
    logic  ins_here;
    logic  rm_here;

    // insert point: first valid cell whose deadline is after the new one, or first empty
    assign ins_here = prev.ins_here || !valid_reg || after(dl_reg, bc.dl);
    assign rm_here  = prev.rm_here || (valid_reg && slot_reg == bc.slot);

    assign self.valid    = valid_reg;
    assign self.slot     = slot_reg;
    assign self.dl       = dl_reg;
    assign self.ins_here = ins_here;
    assign self.rm_here  = rm_here;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (bc.cmd)
                CMD_INSERT:
                begin
                    if (prev.ins_here)
                    begin
                        valid_reg <= prev.valid;
                    end
                    else if (ins_here)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (rm_here)
                    begin
                        valid_reg <= nxt.valid;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (bc.cmd)
            CMD_INSERT:
            begin
                if (prev.ins_here)
                begin
                    slot_reg <= prev.slot;
                    dl_reg   <= prev.dl;
                end
                else if (ins_here)
                begin
                    slot_reg <= bc.slot;
                    dl_reg   <= bc.dl;
                end
            end
            CMD_REMOVE:
            begin
                if (rm_here)
                begin
                    slot_reg <= nxt.slot;
                    dl_reg   <= nxt.dl;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// deadline-sorted timer queue built as a shifting chain of cells
// ----------------------------------------------------------------------------
//  channel   | signals                                         | handshake
//  command   | action slot_id time_value now                   | start, busy
//  result    | kind fired_slot fired_deadline status           | strobe
//            | next_valid next_delay last                      |
//
// a set or cancel runs accept, a chain update unless refused or not queued, then status
// a tick handles each due timer in turn (fire, then requeue or idle), then gives status
// the chain updates all cells together: every cell compares against the broadcast
// reset empties the queue and clears all periods and queued marks at once
// results cannot be stalled; busy stays high until the status item is out
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [3:0]  slot_id,
    input  logic [31:0] time_value,
    input  logic [31:0] now,
    output logic        strobe,
    output logic        kind,
    output logic [3:0]  fired_slot,
    output logic [31:0] fired_deadline,
    output logic [1:0]  status,
    output logic        next_valid,
    output logic [31:0] next_delay,
    output logic        last
);
    state_t state_reg, state_next;

    // captured command
    logic [1:0] act_reg;
    slot_t      slot_reg;
    time_t      tv_reg;
    time_t      now_reg;
    logic [1:0] st_reg, st_next;

    // per-slot side tables (flip-flops, read by fixed index or one mux)
    time_t                 period_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] queued_reg;
    logic [NUM_TIMERS-1:0] fired_reg;
    slot_t                 hslot_reg;   // slot fired last, for requeue

    bcast_t bc;
    cell_t  cells [NUM_TIMERS+2];       // index 0 head edge, last is tail edge

    // head edge: nothing shifts in from before the head
    assign cells[0] = '{valid: 1'b0, slot: '0, dl: '0, ins_here: 1'b0, rm_here: 1'b0};
    assign cells[NUM_TIMERS+1] = '{valid: 1'b0, slot: '0, dl: '0,
                                   ins_here: 1'b1, rm_here: 1'b1};

    genvar g;
    generate
        for (g = 1; g <= NUM_TIMERS; g++)
        begin : g_cell
            sdtq_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .bc   (bc),
                .prev (cells[g-1]),
                .nxt  (cells[g+1]),
                .self (cells[g])
            );
        end
    endgenerate

    time_t tv_nz;
    logic  head_due;
    cell_t head;
    time_t hdiff;

    assign tv_nz    = (tv_reg == '0) ? time_t'(1) : tv_reg;
    assign head     = cells[1];
    assign head_due = head.valid && !after(head.dl, now_reg) && !fired_reg[head.slot];
    assign hdiff    = head.dl - now_reg;
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        bc             = '{cmd: CMD_NONE, slot: slot_reg, dl: now_reg + tv_nz + time_t'(1)};
        strobe         = 1'b0;
        kind           = 1'b0;
        fired_slot     = '0;
        fired_deadline = '0;
        status         = ST_OK;
        next_valid     = 1'b0;
        next_delay     = '0;
        last           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next    = ST_OK;
                    state_next = (action == ACT_TICK) ? S_TICK : S_CMD;
                end
            end
            S_CMD:
            begin
                state_next = S_STATUS;
                if (act_reg == ACT_CANCEL)
                begin
                    st_next = queued_reg[slot_reg] ? ST_OK : ST_NOTQ;
                    if (queued_reg[slot_reg])
                    begin
                        bc.cmd = CMD_REMOVE;
                    end
                end
                else if (queued_reg[slot_reg])
                begin
                    st_next = ST_REFUSED;
                end
                else
                begin
                    st_next = ST_OK;
                    bc.cmd  = CMD_INSERT;
                end
            end
            S_TICK:
            begin
                if (head_due)
                begin
                    // fire the head and drop it from the chain
                    bc.cmd         = CMD_REMOVE;
                    bc.slot        = head.slot;
                    strobe         = 1'b1;
                    fired_slot     = head.slot;
                    fired_deadline = head.dl;
                    state_next     = S_REQ;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_REQ:
            begin
                // periodic timers go back in at now plus period
                bc.slot    = hslot_reg;
                bc.dl      = now_reg + period_reg[hslot_reg];
                if (period_reg[hslot_reg] != '0)
                begin
                    bc.cmd = CMD_INSERT;
                end
                state_next = S_TICK;
            end
            S_STATUS:
            begin
                strobe     = 1'b1;
                kind       = 1'b1;
                last       = 1'b1;
                status     = st_reg;
                next_valid = head.valid;
                if (head.valid && after(head.dl, now_reg))
                begin
                    next_delay = hdiff;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            fired_reg  <= '0;
            st_reg     <= ST_OK;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                period_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (state_reg == S_IDLE && start)
            begin
                fired_reg <= '0;
            end
            if (state_reg == S_CMD)
            begin
                if (act_reg == ACT_CANCEL)
                begin
                    queued_reg[slot_reg] <= 1'b0;
                    period_reg[slot_reg] <= '0;
                end
                else if (!queued_reg[slot_reg])
                begin
                    queued_reg[slot_reg] <= 1'b1;
                    period_reg[slot_reg] <= (act_reg == ACT_PERIODIC) ? tv_nz : '0;
                end
            end
            if (state_reg == S_TICK && head_due)
            begin
                fired_reg[head.slot]  <= 1'b1;
                queued_reg[head.slot] <= 1'b0;
            end
            if (state_reg == S_REQ && period_reg[hslot_reg] != '0)
            begin
                queued_reg[hslot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg  <= action;
            slot_reg <= slot_id;
            tv_reg   <= time_value;
            now_reg  <= now;
        end
        if (state_reg == S_TICK)
        begin
            hslot_reg <= head.slot;
        end
    end

endmodule

// ===== sv/sdtq_checker.sv =====
// ----------------------------------------------------------------------------
// sdtq_checker
// port-level checks of the timer queue
// ----------------------------------------------------------------------------
module sdtq_checker
    import sdtq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic        kind,
    input logic [1:0]  status,
    input logic        next_valid,
    input logic [31:0] next_delay,
    input logic        last
);
    // an accepted item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // status item is the last one and ends the work
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind) |=> !busy)
        else $error("busy after status item");

    // fired items carry no status and are never last
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !kind) |-> (!last && status == ST_OK && !next_valid))
        else $error("bad fired item");

    // empty queue reports no delay
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind && !next_valid) |-> (next_delay == '0))
        else $error("delay on empty queue");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .strobe    (strobe),
    .kind      (kind),
    .status    (status),
    .next_valid(next_valid),
    .next_delay(next_delay),
    .last      (last)
);
